// ===== rtl/dbba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dbba_pkg
// Shared widths, codes and the table control bundle of the double-ended
// bump allocator.
// ---------------------------------------------------------------------------
package dbba_pkg;

   localparam int unsigned REGION_BYTES = 1048576;
   localparam int unsigned MAX_OBJS     = 64;

   localparam int unsigned ADDR_W = 21;
   localparam int unsigned SUM_W  = ADDR_W + 2;
   localparam int unsigned IDX_W  = $clog2(MAX_OBJS);
   localparam int unsigned CNT_W  = $clog2(MAX_OBJS + 1);
   localparam int unsigned KIND_W = 3;
   localparam int unsigned ERR_W  = 2;

   localparam logic [ADDR_W-1:0] REGION     = ADDR_W'(REGION_BYTES);
   localparam logic [SUM_W-1:0]  REGION_SUM = SUM_W'(REGION_BYTES);

   typedef enum logic [KIND_W-1:0] {
      KIND_BUMP_ALLOC = 3'd0,
      KIND_BUMP_RESET = 3'd1,
      KIND_TEMP_ALLOC = 3'd2,
      KIND_TEMP_FREE  = 3'd3,
      KIND_MOVE       = 3'd4
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK      = 2'd0,
      ERR_OOM     = 2'd1,
      ERR_FULL    = 2'd2,
      ERR_INVALID = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // control broadcast to every cell of the table chain
   typedef struct packed {
      logic              shift;
      logic              load;
      logic [IDX_W-1:0]  lo;
      logic [IDX_W-1:0]  hi;
      logic [ADDR_W-1:0] value;
   } tbl_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/dbba_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dbba_cell
// One entry of the object table: shifts toward the head or loads the
// broadcast value when its index falls in the load range.
// ---------------------------------------------------------------------------
module dbba_cell (
   input  logic                           clock,
   input  dbba_pkg::tbl_ctl_type          ctl,
   input  logic [dbba_pkg::IDX_W-1:0]     index,
   input  logic [dbba_pkg::ADDR_W-1:0]    shift_in,
   output logic [dbba_pkg::ADDR_W-1:0]    value
);
   import dbba_pkg::*;

   logic [ADDR_W-1:0] value_ff;
   logic [ADDR_W-1:0] value_in;
   logic              hit;

   assign hit = ctl.load && (index >= ctl.lo) && (index <= ctl.hi);

   always_comb begin
      value_in = value_ff;
      if (hit) begin
         value_in = ctl.value;
      end else if (ctl.shift) begin
         value_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

// ===== rtl/dbba_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dbba_table
// Chain of table cells; every shift moves each entry one place toward the
// head, and the head entry is presented for the free scan.
// ---------------------------------------------------------------------------
module dbba_table (
   input  logic                           clock,
   input  dbba_pkg::tbl_ctl_type          ctl,
   output logic [dbba_pkg::ADDR_W-1:0]    head
);
   import dbba_pkg::*;

   logic [ADDR_W-1:0] val [MAX_OBJS];

   for (genvar i = 0; i < MAX_OBJS; i++) begin : g_cell
      logic [ADDR_W-1:0] nxt;
      if (i == MAX_OBJS - 1) begin : g_last
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = val[i+1];
      end
      dbba_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .index    (IDX_W'(i)),
         .shift_in (nxt),
         .value    (val[i])
      );
   end

   assign head = val[0];

endmodule
`default_nettype wire

// ===== rtl/double_ended_bump_allocator_core.sv =====
// Alloc, reset and unknown-kind items go from accept through the done state to the result
// register, as does a free or move whose address lies past the region end or that finds no
// live object; any other free or move first scans the count live temp objects (0..64).
// One item is in work at a time; the next item is accepted the cycle after the result is
// registered, and a result held off by rsp_ready stalls the input.
// Synchronous active-high reset clears levels, count and handshake state; table as is.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// double_ended_bump_allocator_core
// Offset allocator with an upward bump area and a downward temporary area
// tracked by a table of live temporary objects.
// ---------------------------------------------------------------------------
module double_ended_bump_allocator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [dbba_pkg::KIND_W-1:0]    req_kind,
   input  logic [dbba_pkg::ADDR_W-1:0]    req_size,
   input  logic [dbba_pkg::ADDR_W-1:0]    req_mark,
   input  logic [dbba_pkg::ADDR_W-1:0]    req_address,
   input  logic [dbba_pkg::ADDR_W-1:0]    req_copy_offset,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dbba_pkg::ADDR_W-1:0]    rsp_alloc_address,
   output logic [dbba_pkg::ADDR_W-1:0]    rsp_copy_source,
   output logic [dbba_pkg::ERR_W-1:0]     rsp_error,
   output logic [dbba_pkg::ADDR_W-1:0]    rsp_bump_used,
   output logic [dbba_pkg::ADDR_W-1:0]    rsp_temp_used,
   output logic [dbba_pkg::CNT_W-1:0]     rsp_temp_count,
   output logic                           rsp_temp_empty
);
   import dbba_pkg::*;

   state_type         state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [ADDR_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] mark_ff, mark_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] coff_ff, coff_in;
   logic [ADDR_W-1:0] dist_ff, dist_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] best_ff, best_in;
   logic [ADDR_W-1:0] bump_ff, bump_in;
   logic [ADDR_W-1:0] temp_ff, temp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_alloc_ff, rsp_alloc_in;
   logic [ADDR_W-1:0] rsp_copy_ff, rsp_copy_in;
   logic [ERR_W-1:0]  rsp_error_ff, rsp_error_in;

   tbl_ctl_type       tbl_ctl;
   logic [ADDR_W-1:0] head;

   logic [CNT_W-1:0]   len_m1;
   logic [CNT_W-1:0]   cnt_m1;
   logic [SUM_W-1:0]   sum_bump;
   logic [SUM_W-1:0]   sum_temp;
   logic [SUM_W-1:0]   sum_move;
   logic [ADDR_W:0]    rounded;
   logic [ADDR_W-1:0]  temp_grown;
   logic               slot_free;
   logic               is_scan_kind;

   dbba_table u_table (
      .clock (clock),
      .ctl   (tbl_ctl),
      .head  (head)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign len_m1 = len_ff - CNT_W'(1);
   assign cnt_m1 = cnt_ff - CNT_W'(1);

   // size rounded up to a multiple of 8 for the temp area
   assign rounded    = ({1'b0, size_ff} + (ADDR_W+1)'(7)) & ~(ADDR_W+1)'(7);
   assign sum_bump   = SUM_W'(bump_ff) + SUM_W'(temp_ff) + SUM_W'(size_ff);
   assign sum_temp   = SUM_W'(bump_ff) + SUM_W'(temp_ff) + SUM_W'(rounded);
   assign sum_move   = SUM_W'(bump_ff) + SUM_W'(best_ff) + SUM_W'(size_ff);
   assign temp_grown = ADDR_W'(SUM_W'(temp_ff) + SUM_W'(rounded));

   assign is_scan_kind = req_kind inside {KIND_TEMP_FREE, KIND_MOVE};

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      size_in      = size_ff;
      mark_in      = mark_ff;
      addr_in      = addr_ff;
      coff_in      = coff_ff;
      dist_in      = dist_ff;
      rem_in       = rem_ff;
      len_in       = len_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      bump_in      = bump_ff;
      temp_in      = temp_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_alloc_in = rsp_alloc_ff;
      rsp_copy_in  = rsp_copy_ff;
      rsp_error_in = rsp_error_ff;
      tbl_ctl      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               size_in  = req_size;
               mark_in  = req_mark;
               addr_in  = req_address;
               coff_in  = req_copy_offset;
               dist_in  = REGION - req_address;
               found_in = 1'b0;
               best_in  = '0;
               len_in   = cnt_ff;
               rem_in   = cnt_ff;
               // an address past the region can match nothing: skip the scan
               if (is_scan_kind && (req_address <= REGION) && (cnt_ff != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_SCAN: begin
            // pop the head; kept entries go back at the tail of the live area
            tbl_ctl.shift = 1'b1;
            if (head == dist_ff) begin
               found_in = 1'b1;
               len_in   = len_m1;
            end else begin
               tbl_ctl.load  = 1'b1;
               tbl_ctl.lo    = len_m1[IDX_W-1:0];
               tbl_ctl.hi    = len_m1[IDX_W-1:0];
               tbl_ctl.value = head;
               if (head > best_ff) begin
                  best_in = head;
               end
            end
            rem_in = rem_ff - CNT_W'(1);
            if (rem_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_alloc_in = '0;
               rsp_copy_in  = '0;
               rsp_error_in = ERR_OK;
               state_in     = ST_IDLE;
               case (kind_ff)
                  KIND_BUMP_ALLOC: begin
                     if (sum_bump >= REGION_SUM) begin
                        rsp_error_in = ERR_OOM;
                     end else begin
                        rsp_alloc_in = bump_ff;
                        bump_in      = bump_ff + size_ff;
                     end
                  end
                  KIND_BUMP_RESET: begin
                     if (mark_ff > REGION) begin
                        rsp_error_in = ERR_INVALID;
                     end else begin
                        bump_in = mark_ff;
                     end
                  end
                  KIND_TEMP_ALLOC: begin
                     if (sum_temp >= REGION_SUM) begin
                        rsp_error_in = ERR_OOM;
                     end else if (cnt_ff >= CNT_W'(MAX_OBJS)) begin
                        rsp_error_in = ERR_FULL;
                     end else begin
                        temp_in       = temp_grown;
                        cnt_in        = cnt_ff + CNT_W'(1);
                        rsp_alloc_in  = REGION - temp_grown;
                        tbl_ctl.load  = 1'b1;
                        tbl_ctl.lo    = cnt_ff[IDX_W-1:0];
                        tbl_ctl.hi    = cnt_ff[IDX_W-1:0];
                        tbl_ctl.value = temp_grown;
                     end
                  end
                  KIND_TEMP_FREE: begin
                     if (!found_ff) begin
                        rsp_error_in = ERR_INVALID;
                     end else begin
                        temp_in = best_ff;
                        cnt_in  = len_ff;
                     end
                  end
                  KIND_MOVE: begin
                     if (!found_ff) begin
                        rsp_error_in = ERR_INVALID;
                     end else if (sum_move >= REGION_SUM) begin
                        // undo the removal: dropped entries all equal the distance
                        rsp_error_in  = ERR_OOM;
                        tbl_ctl.load  = 1'b1;
                        tbl_ctl.lo    = len_ff[IDX_W-1:0];
                        tbl_ctl.hi    = cnt_m1[IDX_W-1:0];
                        tbl_ctl.value = dist_ff;
                     end else begin
                        temp_in      = best_ff;
                        cnt_in       = len_ff;
                        rsp_alloc_in = bump_ff;
                        bump_in      = bump_ff + size_ff;
                        rsp_copy_in  = addr_ff + coff_ff;
                     end
                  end
                  default: begin
                     rsp_error_in = ERR_INVALID;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bump_ff      <= '0;
         temp_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bump_ff      <= bump_in;
         temp_ff      <= temp_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      size_ff      <= size_in;
      mark_ff      <= mark_in;
      addr_ff      <= addr_in;
      coff_ff      <= coff_in;
      dist_ff      <= dist_in;
      rem_ff       <= rem_in;
      len_ff       <= len_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      rsp_alloc_ff <= rsp_alloc_in;
      rsp_copy_ff  <= rsp_copy_in;
      rsp_error_ff <= rsp_error_in;
   end

   // levels and count are reported after the item has been applied
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && slot_free) begin
         rsp_bump_used  <= bump_in;
         rsp_temp_used  <= temp_in;
         rsp_temp_count <= cnt_in;
         rsp_temp_empty <= (temp_in == '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alloc_address = rsp_alloc_ff;
   assign rsp_copy_source   = rsp_copy_ff;
   assign rsp_error         = rsp_error_ff;

`ifndef SYNTHESIS
   a_scan_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> rem_ff != '0 && rem_ff <= len_ff)
      else $error("scan running with no entries left");

   a_len_le_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> len_ff <= cnt_ff)
      else $error("kept length exceeds object count");

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_OBJS))
      else $error("object count beyond table depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("accepted item did not start work");
`endif

endmodule
`default_nettype wire
